### hw/rtl/telemetry_frame_builder_top_macros.svh
// ----------------------------------------------------------------------------
// Telemetry frame builder assertion macros
// Shorthand for the clocked properties used by the port checker.
// ----------------------------------------------------------------------------
`ifndef TELEMETRY_FRAME_BUILDER_TOP_MACROS_SVH
`define TELEMETRY_FRAME_BUILDER_TOP_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define TFB_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("telemetry frame builder: next-cycle check failed");

// The consequent must hold in the same cycle as the antecedent.
`define TFB_ASSERT_SAME(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("telemetry frame builder: same-cycle check failed");

`endif

### hw/rtl/tfb_pkg.sv
// ----------------------------------------------------------------------------
// Telemetry frame builder package
// Request types and frame constants shared by the frame builder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tfb_pkg;

  localparam int MEAS_COUNT = 6;
  localparam int MEAS_WIDTH = 20;
  localparam int WORD_WIDTH = 16;
  localparam int FRAME_LEN  = 18;
  localparam int IDX_WIDTH  = 5;

  localparam logic [7:0] FRAME_HEAD  = 8'hAA;
  localparam logic [7:0] FRAME_ADDR  = 8'hFF;
  localparam logic [7:0] PAYLOAD_LEN = 8'd12;

  localparam logic [IDX_WIDTH-1:0] IDX_HEAD  = 5'd0;
  localparam logic [IDX_WIDTH-1:0] IDX_ADDR  = 5'd1;
  localparam logic [IDX_WIDTH-1:0] IDX_ID    = 5'd2;
  localparam logic [IDX_WIDTH-1:0] IDX_LEN   = 5'd3;
  localparam logic [IDX_WIDTH-1:0] IDX_WORD0 = 5'd4;
  localparam logic [IDX_WIDTH-1:0] IDX_SUM   = 5'd16;
  localparam logic [IDX_WIDTH-1:0] IDX_AC    = 5'd17;

  typedef struct packed {
    logic        [7:0]            frame_id;
    logic signed [MEAS_WIDTH-1:0] heater_temp;
    logic signed [MEAS_WIDTH-1:0] sensor_temp;
    logic signed [MEAS_WIDTH-1:0] pressure;
    logic signed [MEAS_WIDTH-1:0] airspeed;
    logic signed [MEAS_WIDTH-1:0] attack_angle;
    logic signed [MEAS_WIDTH-1:0] sideslip_angle;
  } rec_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } tx_t;

endpackage

### hw/rtl/tfb_scale.sv
// ----------------------------------------------------------------------------
// Telemetry frame builder measurement scaler
// Multiplies a Q15.4 value by ten, truncates toward zero and saturates to int16.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tfb_scale (
  input  logic signed [tfb_pkg::MEAS_WIDTH-1:0] raw,
  output logic        [tfb_pkg::WORD_WIDTH-1:0] word
);
  import tfb_pkg::*;

  localparam int ProdWidth = MEAS_WIDTH + 4;
  localparam int QuotWidth = ProdWidth - 4;

  logic signed [ProdWidth-1:0] raw_ext;
  logic signed [ProdWidth-1:0] prod;
  logic signed [ProdWidth-1:0] biased;
  logic signed [QuotWidth-1:0] quot;

  localparam logic signed [QuotWidth-1:0] SatHi = QuotWidth'(32767);
  localparam logic signed [QuotWidth-1:0] SatLo = -QuotWidth'(32768);

  always_comb begin
    raw_ext = ProdWidth'(raw);
    prod    = (raw_ext <<< 3) + (raw_ext <<< 1);
    // A negative product is biased so that the shift truncates toward zero.
    biased  = prod + (prod[ProdWidth-1] ? ProdWidth'(15) : ProdWidth'(0));
    quot    = QuotWidth'(biased >>> 4);
    priority if (quot > SatHi) begin
      word = 16'h7FFF;
    end else if (quot < SatLo) begin
      word = 16'h8000;
    end else begin
      word = quot[WORD_WIDTH-1:0];
    end
  end

endmodule

### hw/rtl/telemetry_frame_builder_top.sv
// ----------------------------------------------------------------------------
// Telemetry frame builder
// Turns one telemetry request into an 18-byte frame sent one byte per cycle while tx is not stalled.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake              Payload
//  rec      in         rec_valid / rec_stall  rec_data (tfb_pkg::rec_t)
//  tx       out        tx_valid / tx_stall    tx_data  (tfb_pkg::tx_t)
//
// Each request yields 18 bytes, so the single byte output port limits how often
// the block takes a request, and any stall on tx lowers that further.
// Scaling is done as the request is taken; one request waits in a holding
// register while the previous frame is sent, and frames follow without a gap.
// Reset empties the holding register, the serialiser and the output register.
// A stall on tx holds the current byte; rec stalls once the holding register
// is full and cannot move on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module telemetry_frame_builder_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            rec_valid,
  output logic            rec_stall,
  input  tfb_pkg::rec_t   rec_data,
  output logic            tx_valid,
  input  logic            tx_stall,
  output tfb_pkg::tx_t    tx_data
);
  import tfb_pkg::*;

  logic [WORD_WIDTH-1:0] scaled [MEAS_COUNT];
  logic signed [MEAS_WIDTH-1:0] meas [MEAS_COUNT];

  logic                  hold_valid;
  logic [7:0]            hold_id;
  logic [WORD_WIDTH-1:0] hold_words [MEAS_COUNT];

  logic                  busy;
  logic [IDX_WIDTH-1:0]  idx;
  logic [7:0]            cur_id;
  logic [WORD_WIDTH-1:0] cur_words [MEAS_COUNT];
  logic [7:0]            sum;
  logic [7:0]            ac;

  logic                  out_adv;
  logic                  load;
  logic                  accept;
  logic [IDX_WIDTH-1:0]  woff;
  logic [2:0]            wsel;
  logic [WORD_WIDTH-1:0] wsel_word;
  logic [7:0]            byte_sel;
  logic [7:0]            sum_next;

  assign meas[0] = rec_data.heater_temp;
  assign meas[1] = rec_data.sensor_temp;
  assign meas[2] = rec_data.pressure;
  assign meas[3] = rec_data.airspeed;
  assign meas[4] = rec_data.attack_angle;
  assign meas[5] = rec_data.sideslip_angle;

  for (genvar g = 0; g < MEAS_COUNT; g++) begin : g_scale
    tfb_scale u_scale (
      .raw  (meas[g]),
      .word (scaled[g])
    );
  end

  assign out_adv   = !tx_valid || !tx_stall;
  assign load      = hold_valid && (!busy || (out_adv && idx == IDX_AC));
  assign rec_stall = hold_valid && !load;
  assign accept    = rec_valid && !rec_stall;

  always_comb begin
    woff      = idx - IDX_WORD0;
    wsel      = woff[3:1];
    wsel_word = (wsel <= 3'(MEAS_COUNT - 1)) ? cur_words[wsel] : '0;
    priority if (idx == IDX_HEAD) begin
      byte_sel = FRAME_HEAD;
    end else if (idx == IDX_ADDR) begin
      byte_sel = FRAME_ADDR;
    end else if (idx == IDX_ID) begin
      byte_sel = cur_id;
    end else if (idx == IDX_LEN) begin
      byte_sel = PAYLOAD_LEN;
    end else if (idx < IDX_SUM) begin
      byte_sel = woff[0] ? wsel_word[15:8] : wsel_word[7:0];
    end else if (idx == IDX_SUM) begin
      byte_sel = sum;
    end else begin
      byte_sel = ac;
    end
    sum_next = sum + byte_sel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (load) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_id    <= rec_data.frame_id;
      hold_words <= scaled;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (out_adv && busy) begin
      busy <= (idx != IDX_AC);
      idx  <= idx + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_id    <= hold_id;
      cur_words <= hold_words;
      sum       <= '0;
      ac        <= '0;
    end else if (out_adv && busy && idx < IDX_SUM) begin
      sum <= sum_next;
      ac  <= ac + sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_valid <= 1'b0;
    end else if (out_adv) begin
      tx_valid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      tx_data.frame_byte <= byte_sel;
      tx_data.last_byte  <= (idx == IDX_AC);
    end
  end

endmodule

### hw/rtl/tfb_checker.sv
// ----------------------------------------------------------------------------
// Telemetry frame builder port checker
// Watches the top level ports for handshake and framing faults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "telemetry_frame_builder_top_macros.svh"

module tfb_checker (
  input logic          clk,
  input logic          rst,
  input logic          rec_valid,
  input logic          rec_stall,
  input tfb_pkg::rec_t rec_data,
  input logic          tx_valid,
  input logic          tx_stall,
  input tfb_pkg::tx_t  tx_data
);
  import tfb_pkg::*;

  logic tx_take;
  logic tx_last_take;

  assign tx_take      = tx_valid && !tx_stall;
  assign tx_last_take = tx_take && tx_data.last_byte;

  // A stalled byte must stay presented and unchanged.
  `TFB_ASSERT_NEXT(a_tx_hold, tx_valid && tx_stall, tx_valid && $stable(tx_data))
  // Straight after reset no byte is offered and requests are taken.
  `TFB_ASSERT_SAME(a_reset_empty, $past(rst), !tx_valid && !rec_stall)
  // A frame is longer than one byte, so two final bytes never follow each other.
  `TFB_ASSERT_NEXT(a_last_spacing, tx_last_take, !(tx_valid && tx_data.last_byte))
  // A stalled request stays offered and unchanged.
  `TFB_ASSERT_NEXT(a_rec_hold, rec_valid && rec_stall, rec_valid && $stable(rec_data))

endmodule

bind telemetry_frame_builder_top tfb_checker u_tfb_checker (
  .clk       (clk),
  .rst       (rst),
  .rec_valid (rec_valid),
  .rec_stall (rec_stall),
  .rec_data  (rec_data),
  .tx_valid  (tx_valid),
  .tx_stall  (tx_stall),
  .tx_data   (tx_data)
);
